>>> hw/rtl/dpis_pkg.sv
// shared constants and types of the dirac parse-info synchronizer
package dpis_pkg;

	// width of the next and previous offsets as they are compared
	localparam int unsigned OFFSET_BITS = 32;

	// a parse-info header is 13 bytes: prefix, code, next, previous
	localparam int unsigned HDR_LEN   = 13;
	localparam int unsigned FILL_BITS = $clog2(HDR_LEN + 1);

	// queue between classifier and sync tracker, power of two deep
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef logic [OFFSET_BITS-1:0] offset_t;

	localparam offset_t OFFSET_MAX  = '1;
	localparam offset_t HDR_LEN_OFF = offset_t'(HDR_LEN);

	// prefix characters of a parse-info header
	localparam logic [7:0] PREFIX_B = 8'h42;
	localparam logic [7:0] PREFIX_C = 8'h43;
	localparam logic [7:0] PREFIX_D = 8'h44;

	typedef enum logic [1:0] {
		SYNC_SEARCH   = 2'd0,
		SYNC_RECORDED = 2'd1,
		SYNC_LOCKED   = 2'd2
	} sync_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       in_unit;
		logic       unit_first;
		logic       unit_last;
		logic [7:0] unit_code;
		logic [1:0] sync_status;
	} out_item_t;

	// what the classifier finds at the head of the delay line
	typedef struct packed {
		logic       full;
		logic       is_hdr;
		logic [7:0] head;
		logic [7:0] code;
		offset_t    nxt;
		offset_t    prv;
	} hdr_info_t;

endpackage

>>> hw/rtl/dpis_stream_if.sv
// valid/ready stream interfaces for the input bytes and the tagged bytes
interface dpis_in_if;
	logic                 valid;
	logic                 ready;
	dpis_pkg::in_item_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dpis_out_if;
	logic                 valid;
	logic                 ready;
	dpis_pkg::out_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/dpis_front.sv
// delay line and header classifier of the parse-info synchronizer
module dpis_front (
	input  logic                clk,
	input  logic                arst_n,
	dpis_in_if.sink             stream,
	output dpis_pkg::hdr_info_t info,
	output logic                info_valid,
	input  logic                info_ready
);

	localparam logic [dpis_pkg::FILL_BITS-1:0] FILL_FULL =
		dpis_pkg::FILL_BITS'(dpis_pkg::HDR_LEN);
	localparam logic [dpis_pkg::FILL_BITS-1:0] FILL_LAST =
		dpis_pkg::FILL_BITS'(dpis_pkg::HDR_LEN - 1);

	// the newest twelve bytes are held, the incoming byte completes the window
	logic [7:0]                     window_q [dpis_pkg::HDR_LEN-1];
	logic [7:0]                     win_next [dpis_pkg::HDR_LEN];
	logic [dpis_pkg::FILL_BITS-1:0] fill_q;
	logic                           accept;
	logic [31:0]                    nxt_raw;
	logic [31:0]                    prv_raw;

	assign accept       = stream.valid && info_ready;
	assign stream.ready = info_ready;
	assign info_valid   = stream.valid;

	// new byte enters at the tail, the head is the oldest byte
	always_comb begin
		for (int i = 0; i < dpis_pkg::HDR_LEN - 1; i++) begin
			win_next[i] = window_q[i];
		end
		win_next[dpis_pkg::HDR_LEN-1] = stream.data.data_byte;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < dpis_pkg::HDR_LEN - 1; i++) begin
				window_q[i] <= win_next[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept && fill_q != FILL_FULL) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	assign nxt_raw = {win_next[5], win_next[6], win_next[7], win_next[8]};
	assign prv_raw = {win_next[9], win_next[10], win_next[11], win_next[12]};

	always_comb begin
		info.full   = (fill_q >= FILL_LAST);
		info.is_hdr = (win_next[0] == dpis_pkg::PREFIX_B) &&
		              (win_next[1] == dpis_pkg::PREFIX_B) &&
		              (win_next[2] == dpis_pkg::PREFIX_C) &&
		              (win_next[3] == dpis_pkg::PREFIX_D);
		info.head   = win_next[0];
		info.code   = win_next[4];
		info.nxt    = nxt_raw[dpis_pkg::OFFSET_BITS-1:0];
		info.prv    = prv_raw[dpis_pkg::OFFSET_BITS-1:0];
	end

endmodule

>>> hw/rtl/dpis_queue.sv
// short queue of classified head bytes between classifier and tracker
module dpis_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  dpis_pkg::hdr_info_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output dpis_pkg::hdr_info_t pop_data
);

	localparam logic [dpis_pkg::QPTR_BITS:0] COUNT_FULL =
		(dpis_pkg::QPTR_BITS + 1)'(dpis_pkg::QUEUE_DEPTH);

	dpis_pkg::hdr_info_t            entry_q [dpis_pkg::QUEUE_DEPTH];
	logic [dpis_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [dpis_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [dpis_pkg::QPTR_BITS:0]   count_q;
	logic                           push;
	logic                           pop;

	assign push_ready = (count_q != COUNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/dpis_back.sv
// sync tracker and output register of the parse-info synchronizer
module dpis_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  dpis_pkg::hdr_info_t e,
	dpis_out_if.source          tag_stream
);

	dpis_pkg::sync_state_t lock_q, lock_d;
	dpis_pkg::offset_t     dist_q, dist_d;
	dpis_pkg::offset_t     next_q, next_d;
	dpis_pkg::offset_t     len_q, len_d;
	logic [7:0]            code_q, code_d;
	dpis_pkg::out_item_t   res_q, res_d;
	logic                  res_valid_q;

	logic                  take;
	dpis_pkg::offset_t     d;
	logic                  d_ok;
	dpis_pkg::offset_t     pos;
	logic                  pos_ge;
	logic                  hdr_follows;
	logic                  hdr_locks;

	assign pop_ready = !res_valid_q || tag_stream.ready;
	assign take      = pop_valid && pop_ready;

	// saturating distance to the last recorded header
	assign d    = (dist_q < dpis_pkg::OFFSET_MAX) ? dist_q + 1'b1 : dpis_pkg::OFFSET_MAX;
	assign d_ok = (d != dpis_pkg::OFFSET_MAX);
	assign pos    = len_q + 1'b1;
	assign pos_ge = (pos >= next_q);

	assign hdr_follows = e.is_hdr && (e.prv == next_q) && (e.nxt >= dpis_pkg::HDR_LEN_OFF);
	assign hdr_locks   = hdr_follows && d_ok && (e.prv == d);

	// next sync state
	always_comb begin
		lock_d = lock_q;
		if (e.full) begin
			unique case (lock_q)
				dpis_pkg::SYNC_LOCKED: begin
					if (pos_ge && !hdr_follows) begin
						lock_d = e.is_hdr ? dpis_pkg::SYNC_RECORDED : dpis_pkg::SYNC_SEARCH;
					end
				end
				dpis_pkg::SYNC_RECORDED: begin
					if (hdr_locks) begin
						lock_d = dpis_pkg::SYNC_LOCKED;
					end
				end
				default: begin
					lock_d = e.is_hdr ? dpis_pkg::SYNC_RECORDED : dpis_pkg::SYNC_SEARCH;
				end
			endcase
		end
	end

	// tracking registers and the tagged byte
	always_comb begin
		dist_d = dist_q;
		next_d = next_q;
		len_d  = len_q;
		code_d = code_q;
		res_d  = '0;
		if (e.full) begin
			res_d.out_byte  = e.head;
			res_d.out_valid = 1'b1;
			unique case (lock_q)
				dpis_pkg::SYNC_LOCKED: begin
					dist_d = d;
					if (pos_ge) begin
						if (hdr_follows) begin
							code_d           = e.code;
							next_d           = e.nxt;
							len_d            = '0;
							dist_d           = '0;
							res_d.in_unit    = 1'b1;
							res_d.unit_first = 1'b1;
							res_d.unit_code  = e.code;
						end else if (e.is_hdr) begin
							next_d = e.nxt;
							dist_d = '0;
						end
					end else begin
						len_d           = pos;
						res_d.in_unit   = 1'b1;
						res_d.unit_last = (pos == next_q - 1'b1);
						res_d.unit_code = code_q;
					end
				end
				dpis_pkg::SYNC_RECORDED: begin
					if (hdr_locks) begin
						code_d           = e.code;
						next_d           = e.nxt;
						len_d            = '0;
						dist_d           = '0;
						res_d.in_unit    = 1'b1;
						res_d.unit_first = 1'b1;
						res_d.unit_code  = e.code;
					end else if (e.is_hdr) begin
						next_d = e.nxt;
						dist_d = '0;
					end else begin
						dist_d = d;
					end
				end
				default: begin
					if (e.is_hdr) begin
						next_d = e.nxt;
						dist_d = '0;
					end else begin
						dist_d = d;
					end
				end
			endcase
		end
		res_d.sync_status = lock_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q      <= dpis_pkg::SYNC_SEARCH;
			dist_q      <= '0;
			next_q      <= '0;
			len_q       <= '0;
			code_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				lock_q <= lock_d;
				dist_q <= dist_d;
				next_q <= next_d;
				len_q  <= len_d;
				code_q <= code_d;
			end
			if (take) begin
				res_valid_q <= 1'b1;
			end else if (tag_stream.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign tag_stream.valid = res_valid_q;
	assign tag_stream.data  = res_q;

`ifndef SYNTHESIS
	a_locked_next_long: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q == dpis_pkg::SYNC_LOCKED |-> next_q >= dpis_pkg::HDR_LEN_OFF)
		else $error("locked with a next offset shorter than a header");

	a_locked_pos_inside: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q == dpis_pkg::SYNC_LOCKED |-> len_q < next_q)
		else $error("unit position ran past the next offset");

	a_first_is_locked: assert property (@(posedge clk) disable iff (!arst_n)
		tag_stream.valid && tag_stream.data.unit_first |->
		tag_stream.data.in_unit && tag_stream.data.sync_status == dpis_pkg::SYNC_LOCKED)
		else $error("unit start tagged outside a locked unit");

	a_no_unit_while_filling: assert property (@(posedge clk) disable iff (!arst_n)
		tag_stream.valid && !tag_stream.data.out_valid |->
		!tag_stream.data.in_unit && tag_stream.data.out_byte == 8'h00)
		else $error("byte tagged before the delay line filled");
`endif

endmodule

>>> hw/rtl/dirac_parse_info_sync.sv
// top level of the dirac parse-info synchronizer
// a transfer taken at the input passes the queue and the output register; its tagged
//   byte is the one that entered 12 transfers before (13-byte delay line)
// throughput: one byte per cycle unless the output stalls, set by the sync tracker step
// the 4-entry queue lets the classifier keep taking bytes while the output stalls
// reset: asynchronous active-low arst_n clears fill count, sync state, offsets, queue
//   and output valid; the delay line needs no clearing and no sweep is run
module dirac_parse_info_sync (
	input  logic       clk,
	input  logic       arst_n,
	dpis_in_if.sink    stream,
	dpis_out_if.source tag_stream
);

	// classified head byte on its way from the classifier into the queue
	dpis_pkg::hdr_info_t front_info;
	logic                front_valid;
	logic                front_ready;

	// classified head byte leaving the queue toward the tracker
	dpis_pkg::hdr_info_t back_info;
	logic                back_valid;
	logic                back_ready;

	// front: delay line, fill count and header pattern match on every transfer
	dpis_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.info       (front_info),
		.info_valid (front_valid),
		.info_ready (front_ready)
	);

	// queue: decouples classification from the tracker and output stalls
	dpis_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_info),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_info)
	);

	// back: search / recorded / locked tracking and the registered tagged byte
	dpis_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.e          (back_info),
		.tag_stream (tag_stream)
	);

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench for the dirac parse-info synchronizer: byte stream in, tagged bytes out
module testbench;

	// generous bound for ~1300 bytes under the worst idling
	localparam int unsigned CYCLE_LIMIT = 400000;
	// idle time after the last owed tag has come out, before the run ends
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned REPORT_MAX = 10;

	logic clk;
	logic arst_n;

	dpis_in_if  byte_in ();
	dpis_out_if tag_out ();

	dirac_parse_info_sync dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (byte_in),
		.tag_stream (tag_out)
	);

	always #5 clk = ~clk;

	// stream bytes still to be offered, and the tags still owed by the block
	logic [7:0]          byte_feed [$];
	dpis_pkg::out_item_t tag_expect [$];
	int unsigned         fed_total;
	int unsigned         fault_count;
	int unsigned         cycle_count;

	// idling odds in percent, changed per phase
	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;

	// shadow of the synchronizer state
	logic [7:0]            delay_line [dpis_pkg::HDR_LEN];
	int unsigned           line_fill = 0;
	dpis_pkg::sync_state_t sync_now = dpis_pkg::SYNC_SEARCH;
	dpis_pkg::offset_t     hdr_gap = '0;    // distance from the last recorded header to the previous head
	dpis_pkg::offset_t     last_next = '0;  // next offset of that header
	dpis_pkg::offset_t     unit_pos = '0;   // position of the previous head byte in the locked unit
	logic [7:0]            cur_code = '0;

	// shift one byte into the delay line and work out the tag of the byte leaving it
	function automatic dpis_pkg::out_item_t tag_byte(logic [7:0] b);
		dpis_pkg::out_item_t r;
		logic                hdr;
		logic [7:0]          code;
		dpis_pkg::offset_t   nxt;
		dpis_pkg::offset_t   prv;
		dpis_pkg::offset_t   d;
		dpis_pkg::offset_t   pos;
		logic                d_ok;
		int                  k;
		r = '0;
		if (line_fill >= dpis_pkg::HDR_LEN) begin
			for (k = 0; k < dpis_pkg::HDR_LEN - 1; k++)
				delay_line[k] = delay_line[k + 1];
			delay_line[dpis_pkg::HDR_LEN - 1] = b;
		end else begin
			delay_line[line_fill] = b;
			line_fill++;
		end
		// no header is looked at until the line is full
		if (line_fill == dpis_pkg::HDR_LEN) begin
			hdr = delay_line[0] == dpis_pkg::PREFIX_B && delay_line[1] == dpis_pkg::PREFIX_B &&
				delay_line[2] == dpis_pkg::PREFIX_C && delay_line[3] == dpis_pkg::PREFIX_D;
			code = delay_line[4];
			nxt = dpis_pkg::offset_t'({delay_line[5], delay_line[6], delay_line[7],
				delay_line[8]});
			prv = dpis_pkg::offset_t'({delay_line[9], delay_line[10], delay_line[11],
				delay_line[12]});
			// distance saturates, and a saturated distance matches nothing
			d = (hdr_gap < dpis_pkg::OFFSET_MAX) ? hdr_gap + 1'b1 : dpis_pkg::OFFSET_MAX;
			d_ok = d < dpis_pkg::OFFSET_MAX;
			r.out_byte = delay_line[0];
			r.out_valid = 1'b1;
			case (sync_now)
				dpis_pkg::SYNC_LOCKED: begin
					pos = unit_pos + 1'b1;
					hdr_gap = d;
					if (pos >= last_next) begin
						// a header is due here
						if (hdr && prv == last_next && nxt >= dpis_pkg::HDR_LEN_OFF) begin
							cur_code = code;
							last_next = nxt;
							unit_pos = '0;
							hdr_gap = '0;
							r.in_unit = 1'b1;
							r.unit_first = 1'b1;
							r.unit_code = code;
						end else if (hdr) begin
							// bad header becomes the recorded one
							sync_now = dpis_pkg::SYNC_RECORDED;
							last_next = nxt;
							hdr_gap = '0;
						end else begin
							sync_now = dpis_pkg::SYNC_SEARCH;
						end
					end else begin
						// inside the unit, headers are ignored
						unit_pos = pos;
						r.in_unit = 1'b1;
						r.unit_last = pos == last_next - 1'b1;
						r.unit_code = cur_code;
					end
				end
				dpis_pkg::SYNC_RECORDED: begin
					if (hdr && d_ok && prv == d && prv == last_next &&
						nxt >= dpis_pkg::HDR_LEN_OFF) begin
						sync_now = dpis_pkg::SYNC_LOCKED;
						cur_code = code;
						last_next = nxt;
						unit_pos = '0;
						hdr_gap = '0;
						r.in_unit = 1'b1;
						r.unit_first = 1'b1;
						r.unit_code = code;
					end else if (hdr) begin
						last_next = nxt;
						hdr_gap = '0;
					end else begin
						hdr_gap = d;
					end
				end
				default: begin
					sync_now = dpis_pkg::SYNC_SEARCH;
					if (hdr) begin
						sync_now = dpis_pkg::SYNC_RECORDED;
						last_next = nxt;
						hdr_gap = '0;
					end else begin
						hdr_gap = d;
					end
				end
			endcase
		end
		r.sync_status = sync_now;
		return r;
	endfunction

	function automatic string fmt_tag(dpis_pkg::out_item_t t);
		return $sformatf("byte %h valid %b unit %b first %b last %b code %h status %0d",
			t.out_byte, t.out_valid, t.in_unit, t.unit_first, t.unit_last, t.unit_code,
			t.sync_status);
	endfunction

	task automatic queue_byte(logic [7:0] b);
		byte_feed.insert(byte_feed.size(), b);
		fed_total++;
	endtask

	// parse-info header: prefix, code, then next and previous offsets big-endian
	task automatic queue_header(logic [7:0] code, logic [31:0] nxt, logic [31:0] prv);
		queue_byte(dpis_pkg::PREFIX_B);
		queue_byte(dpis_pkg::PREFIX_B);
		queue_byte(dpis_pkg::PREFIX_C);
		queue_byte(dpis_pkg::PREFIX_D);
		queue_byte(code);
		for (int k = 3; k >= 0; k--)
			queue_byte(nxt[8*k +: 8]);
		for (int k = 3; k >= 0; k--)
			queue_byte(prv[8*k +: 8]);
	endtask

	// mostly short units, now and then a long one
	function automatic dpis_pkg::offset_t pick_len();
		if ($urandom_range(9) == 0)
			return dpis_pkg::offset_t'($urandom_range(200, 33));
		return dpis_pkg::offset_t'($urandom_range(32, 13));
	endfunction

	// chain of units whose headers point at each other, with the odd fault mixed in
	task automatic queue_unit_chain(int unsigned byte_goal);
		int unsigned       start;
		int unsigned       kind;
		int unsigned       extra;
		int unsigned       body_len;
		int unsigned       k;
		dpis_pkg::offset_t prev_len;
		dpis_pkg::offset_t unit_len;
		dpis_pkg::offset_t nxt_f;
		dpis_pkg::offset_t prv_f;
		logic [7:0]        code;
		start = fed_total;
		// leading noise
		repeat ($urandom_range(20)) queue_byte(8'($urandom));
		prev_len = dpis_pkg::offset_t'($urandom);
		unit_len = pick_len();
		while (fed_total - start < byte_goal) begin
			kind = $urandom_range(99);
			code = 8'($urandom);
			nxt_f = unit_len;
			prv_f = prev_len;
			extra = 0;
			if (kind < 5)
				// one wrong bit in the previous offset
				prv_f = prev_len ^ (dpis_pkg::offset_t'(1) <<
					$urandom_range(dpis_pkg::OFFSET_BITS - 1));
			else if (kind < 9)
				nxt_f = dpis_pkg::offset_t'($urandom_range(dpis_pkg::HDR_LEN - 1));
			else if (kind < 13) begin
				// wild offsets, never a lock
				nxt_f = dpis_pkg::offset_t'($urandom);
				prv_f = dpis_pkg::offset_t'($urandom);
			end else if (kind < 16)
				// next header lands a few bytes late
				extra = $urandom_range(3, 1);
			if (kind >= 16 && kind < 19)
				// header missing where one is due
				repeat (dpis_pkg::HDR_LEN) queue_byte(8'($urandom));
			else
				queue_header(code, nxt_f, prv_f);
			body_len = int'(unit_len) - dpis_pkg::HDR_LEN + extra;
			k = 0;
			if (kind >= 19 && kind < 24 && body_len >= 4) begin
				// stray header prefix inside the unit body
				queue_byte(dpis_pkg::PREFIX_B);
				queue_byte(dpis_pkg::PREFIX_B);
				queue_byte(dpis_pkg::PREFIX_C);
				queue_byte(dpis_pkg::PREFIX_D);
				k = 4;
			end
			while (k < body_len) begin
				queue_byte(8'($urandom));
				k++;
			end
			prev_len = unit_len;
			unit_len = pick_len();
		end
	endtask

	// hand-built opening: filling, lock, one-header units, short next, bad previous,
	// stray prefix inside a unit, and a missing header
	task automatic queue_directed();
		queue_byte(8'h00);
		queue_byte(8'hff);
		queue_header(8'h00, 32'd13, dpis_pkg::OFFSET_MAX);  // recorded
		queue_header(8'hff, 32'd13, 32'd13);                // locks
		queue_header(8'h10, 32'd13, 32'd13);                // stays locked
		queue_header(8'h20, 32'd5, 32'd13);                 // next too short, back to recorded
		queue_header(8'h30, 32'd20, 32'd5);                 // re-recorded
		repeat (7) queue_byte(8'h5a);
		queue_header(8'h40, 32'd13, 32'd20);                // locks
		queue_header(8'h41, 32'd13, 32'd12);                // wrong previous, back to recorded
		queue_header(8'h42, 32'd13, 32'd13);                // locks again
		queue_header(8'h43, 32'd30, 32'd13);                // long unit
		queue_byte(dpis_pkg::PREFIX_B);
		queue_byte(dpis_pkg::PREFIX_B);
		queue_byte(dpis_pkg::PREFIX_C);
		queue_byte(dpis_pkg::PREFIX_D);
		repeat (13) queue_byte(8'($urandom));
		repeat (dpis_pkg::HDR_LEN) queue_byte(8'ha5);      // no header where due, searching
	endtask

	// driver: offer bytes from the feed, predict the tag of each accepted transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_in.valid && byte_in.ready)
				tag_expect.insert(tag_expect.size(), tag_byte(byte_in.data.data_byte));
			if (!byte_in.valid || byte_in.ready) begin
				if (byte_feed.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					byte_in.data.data_byte <= byte_feed[0];
					byte_feed.delete(0);
					byte_in.valid <= 1'b1;
				end else begin
					byte_in.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure, each tagged transfer checked against the oldest tag
	dpis_pkg::out_item_t tag_want;
	always @(posedge clk) begin
		if (arst_n) begin
			tag_out.ready <= $urandom_range(99) >= receiver_stall_pct;
			if (tag_out.valid && tag_out.ready) begin
				if (tag_expect.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("unexpected tagged byte: %s", fmt_tag(tag_out.data));
				end else begin
					tag_want = tag_expect[0];
					tag_expect.delete(0);
					if (tag_out.data.out_byte != tag_want.out_byte ||
						tag_out.data.out_valid != tag_want.out_valid ||
						tag_out.data.in_unit != tag_want.in_unit ||
						tag_out.data.unit_first != tag_want.unit_first ||
						tag_out.data.unit_last != tag_want.unit_last ||
						tag_out.data.unit_code != tag_want.unit_code ||
						tag_out.data.sync_status != tag_want.sync_status) begin
						fault_count++;
						if (fault_count <= REPORT_MAX) begin
							$display("tag mismatch: expected %s", fmt_tag(tag_want));
							$display("              actual   %s", fmt_tag(tag_out.data));
						end
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		byte_in.valid = 1'b0;
		byte_in.data = '0;
		tag_out.ready = 1'b0;
		fed_total = 0;
		fault_count = 0;
		cycle_count = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// idling phases: none, sender gaps, receiver stalls, light both; then none and sender gaps again
		for (int p = 0; p < 6; p++) begin
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 76;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 76;
				end
				default: begin
					sender_idle_pct = 8;
					receiver_stall_pct = 8;
				end
			endcase
			if (p == 0)
				queue_directed();
			queue_unit_chain(160);
			while (byte_feed.size() != 0 || byte_in.valid)
				@(posedge clk);
		end
		// let every owed tag come out, then a little longer
		while (tag_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
